>>> hw/rtl/mssmp_pkg.sv
// ----------------------------------------------------------------------------
// mssmp_pkg
// Shared sizes, types and command/status bundles for the minimum sum of
// segment maxima partition block.
// ----------------------------------------------------------------------------
package mssmp_pkg;

  localparam int MAX_JOBS  = 256;
  localparam int MAX_DAYS  = 16;
  localparam int DIFF_W    = 16;                        // stored difficulty bits
  localparam int DIFF_IN_W = 16;                        // difficulty port width
  localparam int DAY_W     = 5;                         // day_count register width
  localparam int TOTAL_W   = 24;                        // min_total width

  localparam int JOB_AW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W   = $clog2(MAX_JOBS + 1);
  localparam int LANE_W  = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
  localparam int COST_W  = DIFF_W + $clog2(MAX_DAYS + 1);

  localparam logic [DAY_W-1:0]   DAY_RESET = DAY_W'(1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // One cost row: lane l holds the cost for l+1 days left.
  typedef logic [MAX_DAYS-1:0][COST_W-1:0] cost_row_t;

  typedef struct packed {
    logic load;       // take the input transaction
    logic start;      // begin the table fill at the last row
    logic issue;      // read job j and cost row j+1
    logic write_row;  // store the finished row, step to the previous one
    logic finish;     // capture the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic last_j;     // current j is the final job
    logic i_zero;     // working on row 0
    logic busy;       // scan pipeline still holds reads
    logic feasible;   // latched partition check
    logic out_free;   // output register can take a result
  } dp_sts_t;

endpackage

>>> hw/rtl/min_sum_of_segment_max_partition.sv
// Sequence: after the final job the table is filled row by row, each row by a
//   scan of one split point per cycle, a drain of the scan pipeline and a row
//   write; when no partition exists the fill is skipped. The result is then
//   captured once the output register is free.
// Throughput: one job per cycle while loading; no jobs are taken during the fill.
// Reset: control state clears, day_count returns to 1; memories are not cleared.
// ----------------------------------------------------------------------------
// min_sum_of_segment_max_partition
// Splits a loaded job sequence into day_count contiguous groups and reports
// the minimum sum of group maxima.
// ----------------------------------------------------------------------------
module min_sum_of_segment_max_partition (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mssmp_pkg::DAY_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mssmp_pkg::DIFF_IN_W-1:0]    difficulty_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mssmp_pkg::TOTAL_W-1:0]      min_total_o,
  output logic                               infeasible_o,
  output logic                               overflow_o
);

  mssmp_pkg::dp_cmd_t cmd;
  mssmp_pkg::dp_sts_t sts;

  mssmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  mssmp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .difficulty_i (difficulty_i),
    .last_i       (last_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .min_total_o  (min_total_o),
    .infeasible_o (infeasible_o),
    .overflow_o   (overflow_o)
  );

  // final job closes the input until the result is captured into the output register
  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> !in_ready_o)
    else $error("input still open after final job");

  // a new result only comes out of the compute phase
  a_result_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised while loading");

  a_infeasible_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && infeasible_o) |-> (min_total_o == '0))
    else $error("infeasible result with nonzero total");

endmodule

>>> hw/rtl/mssmp_ctrl.sv
// ----------------------------------------------------------------------------
// mssmp_ctrl
// Sequencer: job loading, row-by-row table fill, result hand-off.
// ----------------------------------------------------------------------------
module mssmp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  input  mssmp_pkg::dp_sts_t  sts_i,
  output mssmp_pkg::dp_cmd_t  cmd_o,
  output logic                in_ready_o
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_i) state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d = sts_i.feasible ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_j) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.busy) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write_row = 1'b1;
        state_d = sts_i.i_zero ? ST_FINISH : ST_SCAN;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign in_ready_o = (state_q == ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/mssmp_dp.sv
// ----------------------------------------------------------------------------
// mssmp_dp
// Datapath: job store, cost row memory, scan pipeline with one min lane per
// day count, and the result register.
// ----------------------------------------------------------------------------
module mssmp_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mssmp_pkg::DAY_W-1:0]          cfg_wdata_i,
  input  logic [mssmp_pkg::DIFF_IN_W-1:0]      difficulty_i,
  input  logic                                 last_i,
  input  logic                                 out_ready_i,
  input  mssmp_pkg::dp_cmd_t                   cmd_i,
  output mssmp_pkg::dp_sts_t                   sts_o,
  output logic                                 out_valid_o,
  output logic [mssmp_pkg::TOTAL_W-1:0]        min_total_o,
  output logic                                 infeasible_o,
  output logic                                 overflow_o
);

  localparam int EXT_W = mssmp_pkg::COST_W + mssmp_pkg::TOTAL_W;

  // Memories
  logic [mssmp_pkg::DIFF_W-1:0] jobs_mem [mssmp_pkg::MAX_JOBS];
  mssmp_pkg::cost_row_t         rows_mem [mssmp_pkg::MAX_JOBS];

  // Control state
  logic [mssmp_pkg::DAY_W-1:0] day_count_q;
  logic [mssmp_pkg::CNT_W-1:0] count_q;
  logic                        ovf_seen_q;
  logic                        s1_vld_q, s2_vld_q;
  logic                        out_valid_q;

  // Sequence snapshot
  logic [mssmp_pkg::CNT_W-1:0] n_q;
  logic [mssmp_pkg::DAY_W-1:0] d_q;
  logic                        ovf_q;
  logic                        feas_q;

  // Scan state
  logic [mssmp_pkg::JOB_AW-1:0] i_q, j_q;
  logic [mssmp_pkg::DIFF_W-1:0] peak_q;
  mssmp_pkg::cost_row_t         best_q, best_d;
  logic [mssmp_pkg::DIFF_W-1:0] job_rd_q;
  mssmp_pkg::cost_row_t         row_rd_q, row_s2_q;
  logic [mssmp_pkg::MAX_DAYS-1:0] mask_d, mask_s1_q, mask_s2_q;

  // Result register
  logic [mssmp_pkg::TOTAL_W-1:0] min_total_q;
  logic                          infeasible_q, overflow_q;

  logic                         room;
  logic [mssmp_pkg::CNT_W-1:0]  count_inc;
  logic                         ovf_now;
  logic                         feas_d;
  logic [mssmp_pkg::DIFF_W-1:0] diff;
  logic [mssmp_pkg::CNT_W-1:0]  rem;
  logic [mssmp_pkg::JOB_AW-1:0] j_nx, i_dec;
  logic [mssmp_pkg::COST_W-1:0] cand [mssmp_pkg::MAX_DAYS];
  logic [mssmp_pkg::COST_W-1:0] sel_cost;
  logic [EXT_W-1:0]             sel_ext;
  logic [mssmp_pkg::TOTAL_W-1:0] total_sat;
  logic                         out_free;

  assign diff      = mssmp_pkg::DIFF_W'(difficulty_i);
  assign room      = count_q < mssmp_pkg::CNT_W'(mssmp_pkg::MAX_JOBS);
  assign count_inc = room ? count_q + 1'b1 : count_q;
  assign ovf_now   = ovf_seen_q | ~room;
  assign feas_d    = (day_count_q != '0)
                  && (int'(day_count_q) <= mssmp_pkg::MAX_DAYS)
                  && (count_inc >= mssmp_pkg::CNT_W'(day_count_q));

  assign j_nx  = j_q + 1'b1;
  assign i_dec = i_q - 1'b1;
  assign rem   = n_q - mssmp_pkg::CNT_W'(j_q);

  // Lane l (l+1 days left) may end its first group at j only if enough jobs
  // remain after j; one day left needs the group to run to the end.
  always_comb begin
    for (int l = 0; l < mssmp_pkg::MAX_DAYS; l++) begin
      if (l == 0) mask_d[l] = (rem == mssmp_pkg::CNT_W'(1));
      else        mask_d[l] = (mssmp_pkg::CNT_W'(l + 1) <= rem);
    end
  end

  always_comb begin
    cand[0] = mssmp_pkg::COST_W'(peak_q);
    for (int l = 1; l < mssmp_pkg::MAX_DAYS; l++) begin
      cand[l] = mssmp_pkg::COST_W'(peak_q) + row_s2_q[l-1];
    end
    for (int l = 0; l < mssmp_pkg::MAX_DAYS; l++) begin
      best_d[l] = (mask_s2_q[l] && (cand[l] < best_q[l])) ? cand[l] : best_q[l];
    end
  end

  assign sel_cost  = best_q[mssmp_pkg::LANE_W'(d_q - 1'b1)];
  assign sel_ext   = EXT_W'(sel_cost);
  assign total_sat = (sel_ext > EXT_W'(mssmp_pkg::TOTAL_MAX)) ? mssmp_pkg::TOTAL_MAX
                                                              : sel_ext[mssmp_pkg::TOTAL_W-1:0];
  assign out_free  = ~out_valid_q | out_ready_i;

  // Memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) jobs_mem[count_q[mssmp_pkg::JOB_AW-1:0]] <= diff;
    if (cmd_i.issue) job_rd_q <= jobs_mem[j_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_row) rows_mem[i_q] <= best_q;
    if (cmd_i.issue) row_rd_q <= rows_mem[j_nx];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_count_q <= mssmp_pkg::DAY_RESET;
      count_q     <= '0;
      ovf_seen_q  <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) day_count_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        if (last_i) begin
          count_q    <= '0;
          ovf_seen_q <= 1'b0;
        end else begin
          count_q    <= count_inc;
          ovf_seen_q <= ovf_now;
        end
      end
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.finish)                  out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && last_i) begin
      n_q    <= count_inc;
      d_q    <= day_count_q;
      ovf_q  <= ovf_now;
      feas_q <= feas_d;
    end

    if (cmd_i.issue) mask_s1_q <= mask_d;
    if (s1_vld_q) begin
      row_s2_q  <= row_rd_q;
      mask_s2_q <= mask_s1_q;
    end

    if (cmd_i.start) begin
      i_q    <= mssmp_pkg::JOB_AW'(n_q - 1'b1);
      j_q    <= mssmp_pkg::JOB_AW'(n_q - 1'b1);
      peak_q <= '0;
      best_q <= '1;
    end else if (cmd_i.write_row && (i_q != '0)) begin
      // next row starts one position earlier; row 0 stays for the result
      i_q    <= i_dec;
      j_q    <= i_dec;
      peak_q <= '0;
      best_q <= '1;
    end else begin
      if (cmd_i.issue) j_q <= j_nx;
      if (s1_vld_q && (job_rd_q > peak_q)) peak_q <= job_rd_q;
      if (s2_vld_q) best_q <= best_d;
    end

    if (cmd_i.finish) begin
      min_total_q  <= feas_q ? total_sat : '0;
      infeasible_q <= ~feas_q;
      overflow_q   <= ovf_q;
    end
  end

  assign sts_o.last_j   = (mssmp_pkg::CNT_W'(j_q) + 1'b1) == n_q;
  assign sts_o.i_zero   = (i_q == '0);
  assign sts_o.busy     = s1_vld_q | s2_vld_q;
  assign sts_o.feasible = feas_q;
  assign sts_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign min_total_o  = min_total_q;
  assign infeasible_o = infeasible_q;
  assign overflow_o   = overflow_q;

endmodule
